[hw/rtl/sfs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared types, widths and tables of the steering force shaper.
// ----------------------------------------------------------------------------
package sfs_pkg;

    localparam int PEAK_FORCE_DEF = 10200;
    localparam int ATAN_STEPS_DEF = 16;
    localparam int QDEPTH         = 2;

    localparam int BRAKE_W = 12;
    localparam int DZ_W    = 16;
    localparam int STEEP_W = 24;
    localparam int CFG_W   = 24;
    localparam int SUM_W   = 30;
    localparam int MAG_W   = 29;
    localparam int ARG_W   = MAG_W + STEEP_W;
    localparam int CW      = 57;
    localparam int ZW      = 33;
    localparam int FRAC_Q  = 30;
    localparam int OUT_N_W = 15;
    localparam int OUT_F_W = 16;
    localparam int DIV_D_W = 17;

    localparam logic [1:0] CFG_BRAKING   = 2'd0;
    localparam logic [1:0] CFG_DEADZONE  = 2'd1;
    localparam logic [1:0] CFG_STEEPNESS = 2'd2;

    typedef struct packed {
        logic signed [15:0] left_lateral_n;
        logic signed [15:0] right_lateral_n;
        logic signed [15:0] left_longitudinal_n;
        logic signed [15:0] right_longitudinal_n;
    } frame_t;

    typedef struct packed {
        logic signed [OUT_N_W-1:0] force_newtons;
        logic signed [OUT_F_W-1:0] force_fraction;
    } result_t;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } work_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_MUL,
        B_CORDIC,
        B_SCALE,
        B_DZ,
        B_DIV,
        B_CLAMP,
        B_SMOOTH,
        B_FDIV,
        B_DONE
    } back_state_t;

    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:    v = 30'd843314856;
            5'd1:    v = 30'd497837829;
            5'd2:    v = 30'd263043836;
            5'd3:    v = 30'd133525158;
            5'd4:    v = 30'd67021686;
            5'd5:    v = 30'd33543515;
            5'd6:    v = 30'd16775850;
            5'd7:    v = 30'd8388437;
            5'd8:    v = 30'd4194282;
            5'd9:    v = 30'd2097149;
            5'd10:   v = 30'd1048575;
            5'd11:   v = 30'd524287;
            5'd12:   v = 30'd262143;
            5'd13:   v = 30'd131071;
            5'd14:   v = 30'd65535;
            5'd15:   v = 30'd32767;
            5'd16:   v = 30'd16383;
            5'd17:   v = 30'd8191;
            5'd18:   v = 30'd4095;
            5'd19:   v = 30'd2047;
            5'd20:   v = 30'd1023;
            5'd21:   v = 30'd511;
            5'd22:   v = 30'd255;
            5'd23:   v = 30'd127;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

[hw/rtl/sfs_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfs_front
// Accepts a frame, forms the Q.6 load sum and splits it into sign and size.
// ----------------------------------------------------------------------------
module sfs_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  sfs_pkg::frame_t        frame,
    input  logic [sfs_pkg::BRAKE_W-1:0] braking_scale,
    output logic                   work_valid,
    input  logic                   work_ready,
    output sfs_pkg::work_t         work
);
    import sfs_pkg::*;

    logic                    stage_valid_reg;
    logic                    stage_valid_next;
    work_t                   stage_reg;
    logic                    take;
    logic signed [16:0]      lat_sum;
    logic signed [16:0]      lon_diff;
    logic signed [SUM_W-1:0] lat_ext;
    logic signed [SUM_W-1:0] lon_ext;
    logic signed [SUM_W-1:0] sum6;
    logic signed [SUM_W-1:0] abs6;
    work_t                   cls;

    always_comb
    begin
        lat_sum  = {frame.left_lateral_n[15], frame.left_lateral_n}
                 + {frame.right_lateral_n[15], frame.right_lateral_n};
        lon_diff = {frame.right_longitudinal_n[15], frame.right_longitudinal_n}
                 - {frame.left_longitudinal_n[15], frame.left_longitudinal_n};
        lat_ext  = SUM_W'(lat_sum);
        lon_ext  = SUM_W'(lon_diff);
        sum6     = (lat_ext <<< 6) + lon_ext * $signed({1'b0, braking_scale});
        abs6     = sum6[SUM_W-1] ? -sum6 : sum6;
        cls.neg  = sum6[SUM_W-1];
        cls.mag  = abs6[MAG_W-1:0];
    end

    assign full       = stage_valid_reg && !work_ready;
    assign take       = push && !full;
    assign work_valid = stage_valid_reg;
    assign work       = stage_reg;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (take)
        begin
            stage_valid_next = 1'b1;
        end
        else if (work_ready)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_reg <= cls;
        end
    end

endmodule

[hw/rtl/sfs_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfs_queue
// Short first-in first-out queue of classified words between front and back.
// ----------------------------------------------------------------------------
module sfs_queue #(
    parameter int DEPTH = sfs_pkg::QDEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  sfs_pkg::work_t in_word,
    output logic           out_valid,
    input  logic           out_ready,
    output sfs_pkg::work_t out_word
);
    import sfs_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    work_t         mem [DEPTH];
    logic [PW-1:0] wptr_reg;
    logic [PW-1:0] rptr_reg;
    logic [NW-1:0] count_reg;
    logic          wr;
    logic          rd;

    assign in_ready  = count_reg != NW'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_word  = mem[rptr_reg];
    assign wr        = in_valid && in_ready;
    assign rd        = out_valid && out_ready;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr)
            begin
                wptr_reg <= bump(wptr_reg);
            end
            if (rd)
            begin
                rptr_reg <= bump(rptr_reg);
            end
            if (wr && !rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd && !wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[wptr_reg] <= in_word;
        end
    end

endmodule

[hw/rtl/sfs_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfs_back
// Serial CORDIC arctangent, deadzone with a restoring divider, clamp,
// smoothing and a reciprocal-multiply fraction, with a one-word result register.
// ----------------------------------------------------------------------------
module sfs_back #(
    parameter int PEAK_FORCE = sfs_pkg::PEAK_FORCE_DEF,
    parameter int ATAN_STEPS = sfs_pkg::ATAN_STEPS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        work_valid,
    output logic                        work_ready,
    input  sfs_pkg::work_t              work,
    input  logic [sfs_pkg::DZ_W-1:0]    deadzone_fraction,
    input  logic [sfs_pkg::STEEP_W-1:0] steep_scale,
    output logic                        empty,
    input  logic                        pop,
    output sfs_pkg::result_t            result
);
    import sfs_pkg::*;

    localparam int PW    = 31 + $clog2(PEAK_FORCE + 1);
    localparam int NW    = PW + DZ_W;
    localparam int CNT_W = $clog2(NW + 1);
    localparam int IW    = $clog2(ATAN_STEPS);
    localparam int RSH   = 29 + $clog2(PEAK_FORCE);
    localparam int FSH   = RSH - OUT_N_W;
    localparam longint RECIP_L = ((longint'(1) <<< RSH) + longint'(PEAK_FORCE) - 1)
                               / longint'(PEAK_FORCE);
    localparam logic [29:0] RECIP = 30'(RECIP_L);
    localparam logic [PW-1:0] CAP = PW'(PEAK_FORCE) << FRAC_Q;

    back_state_t             state_reg, state_next;
    logic                    neg_reg, neg_next;
    logic [MAG_W-1:0]        mag_reg, mag_next;
    logic signed [CW-1:0]    x_reg, x_next;
    logic signed [CW-1:0]    y_reg, y_next;
    logic signed [ZW-1:0]    z_reg, z_next;
    logic [IW-1:0]           iter_reg, iter_next;
    logic [PW-1:0]           p_reg, p_next;
    logic [NW-1:0]           quo_reg, quo_next;
    logic [DIV_D_W-1:0]      rem_reg, rem_next;
    logic [DIV_D_W-1:0]      d_reg, d_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [OUT_N_W-1:0] cur_reg, cur_next;
    logic signed [OUT_N_W-1:0] smooth_reg, smooth_next;
    logic signed [OUT_N_W-1:0] prev_reg, prev_next;
    logic                    prev_valid_reg, prev_valid_next;
    logic                    out_valid_reg, out_valid_next;
    result_t                 out_reg, out_next;

    logic [ARG_W-1:0]        arg;
    logic signed [CW-1:0]    dx, dy, atan_ext;
    logic [30:0]             z_clamp;
    logic [PW-1:0]           thresh;
    logic [PW-1:0]           p_cap;
    logic [OUT_N_W-1:0]      cur_mag;
    logic [DIV_D_W:0]        rem_sh;
    logic                    ge;
    logic signed [OUT_N_W:0] pair_sum;
    logic signed [OUT_N_W:0] half;
    logic signed [OUT_N_W-1:0] smooth_val;
    logic [OUT_N_W-1:0]      smooth_abs;
    logic [44:0]             fprod;
    logic [16:0]             fq;
    logic [OUT_F_W-1:0]      fsat;

    assign work_ready = state_reg == B_IDLE;
    assign empty      = !out_valid_reg;
    assign result     = out_reg;

    always_comb
    begin
        arg      = ARG_W'(mag_reg) * ARG_W'(steep_scale);
        dx       = y_reg >>> iter_reg;
        dy       = x_reg >>> iter_reg;
        atan_ext = CW'(atan_q30(5'(iter_reg)));
        z_clamp  = z_reg[ZW-1] ? 31'd0 : z_reg[30:0];
        thresh   = (PW'(PEAK_FORCE) * PW'(deadzone_fraction)) << 14;
        p_cap    = (p_reg > CAP) ? CAP : p_reg;
        cur_mag  = OUT_N_W'(p_cap >> FRAC_Q);
        rem_sh   = {rem_reg, quo_reg[NW-1]};
        ge       = rem_sh >= {1'b0, d_reg};
        pair_sum = {cur_reg[OUT_N_W-1], cur_reg} + {prev_reg[OUT_N_W-1], prev_reg};
        half     = pair_sum[OUT_N_W] ? ((pair_sum + 16'sd1) >>> 1) : (pair_sum >>> 1);
        smooth_val = prev_valid_reg ? half[OUT_N_W-1:0] : cur_reg;
        smooth_abs = smooth_reg[OUT_N_W-1] ? OUT_N_W'(-smooth_reg) : smooth_reg;
        fprod    = 45'(smooth_abs) * 45'(RECIP);
        fq       = quo_reg[16:0];
        fsat     = (fq > 17'd32767) ? 16'd32767 : fq[15:0];
    end

    always_comb
    begin
        state_next      = state_reg;
        neg_next        = neg_reg;
        mag_next        = mag_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        z_next          = z_reg;
        iter_next       = iter_reg;
        p_next          = p_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        d_next          = d_reg;
        cnt_next        = cnt_reg;
        cur_next        = cur_reg;
        smooth_next     = smooth_reg;
        prev_next       = prev_reg;
        prev_valid_next = prev_valid_reg;
        out_valid_next  = out_valid_reg && !pop;
        out_next        = out_reg;
        if (state_reg == B_DIV)
        begin
            rem_next = ge ? DIV_D_W'(rem_sh - {1'b0, d_reg}) : DIV_D_W'(rem_sh);
            quo_next = {quo_reg[NW-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
        end
        case (state_reg)
            B_IDLE:
            begin
                if (work_valid)
                begin
                    neg_next   = work.neg;
                    mag_next   = work.mag;
                    state_next = B_MUL;
                end
            end
            B_MUL:
            begin
                x_next    = CW'(64'd1 << FRAC_Q);
                y_next    = CW'(arg);
                z_next    = '0;
                iter_next = '0;
                state_next = (arg == '0) ? B_SCALE : B_CORDIC;
            end
            B_CORDIC:
            begin
                if (y_reg > 0)
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + ZW'(atan_ext);
                end
                else
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - ZW'(atan_ext);
                end
                iter_next = IW'(iter_reg + 1'b1);
                if (iter_reg == IW'(ATAN_STEPS - 1))
                begin
                    state_next = B_SCALE;
                end
            end
            B_SCALE:
            begin
                p_next     = PW'(z_clamp) * PW'(PEAK_FORCE);
                state_next = B_DZ;
            end
            B_DZ:
            begin
                if (deadzone_fraction == '0)
                begin
                    state_next = B_CLAMP;
                end
                else if (p_reg <= thresh)
                begin
                    p_next     = '0;
                    state_next = B_CLAMP;
                end
                else
                begin
                    quo_next   = NW'(p_reg - thresh) << DZ_W;
                    rem_next   = '0;
                    d_next     = DIV_D_W'(17'd65536 - {1'b0, deadzone_fraction});
                    cnt_next   = CNT_W'(NW);
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                if (cnt_reg == CNT_W'(1))
                begin
                    p_next     = '0;
                    state_next = B_CLAMP;
                end
            end
            B_CLAMP:
            begin
                cur_next   = neg_reg ? OUT_N_W'(-cur_mag) : cur_mag;
                state_next = B_SMOOTH;
            end
            B_SMOOTH:
            begin
                smooth_next     = smooth_val;
                prev_next       = cur_reg;
                prev_valid_next = 1'b1;
                state_next      = B_FDIV;
            end
            B_FDIV:
            begin
                quo_next   = NW'(fprod >> FSH);
                state_next = B_DONE;
            end
            B_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_valid_next         = 1'b1;
                    out_next.force_newtons = smooth_reg;
                    out_next.force_fraction = smooth_reg[OUT_N_W-1]
                                            ? OUT_F_W'(-fsat) : fsat;
                    state_next             = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
        if (state_reg == B_DIV && cnt_reg == CNT_W'(1))
        begin
            p_next = (quo_next > NW'(CAP)) ? CAP : PW'(quo_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            prev_reg       <= '0;
            prev_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            prev_reg       <= prev_next;
            prev_valid_reg <= prev_valid_next;
            out_valid_reg  <= out_valid_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg    <= neg_next;
        mag_reg    <= mag_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        z_reg      <= z_next;
        iter_reg   <= iter_next;
        p_reg      <= p_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        d_reg      <= d_next;
        cur_reg    <= cur_next;
        smooth_reg <= smooth_next;
        out_reg    <= out_next;
    end

endmodule

[hw/rtl/steering_force_shaper_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// steering_force_shaper_core
// Shapes four front tyre forces into a smoothed steering force word.
//
// Input channel: frame words go in on push while full is low. The front
// registers the load sum, a two-word queue decouples it from the back.
// Result channel: the oldest result sits on result while empty is low and
// leaves on pop. One result register holds it; a stalled receiver stops
// the back at its last step while the front and queue take frames until full.
// Configuration: cfg_write with cfg_index 0 braking scale, 1 deadzone,
// 2 curve steepness; other indexes are dropped. Write only while idle.
// Back cost per word is set by the serial CORDIC loop, which is skipped when
// the arctangent argument is zero, and by a PEAK-dependent divider pass when
// a deadzone is set and exceeded. The back takes a new word only when idle;
// words reach it through the front register and the queue.
// Reset clears history, empties queue and result register, loads register defaults.
// ----------------------------------------------------------------------------
module steering_force_shaper_core #(
    parameter int PEAK_FORCE = sfs_pkg::PEAK_FORCE_DEF,
    parameter int ATAN_STEPS = sfs_pkg::ATAN_STEPS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  sfs_pkg::frame_t           frame,
    output logic                      empty,
    input  logic                      pop,
    output sfs_pkg::result_t          result,
    input  logic                      cfg_write,
    input  logic [1:0]                cfg_index,
    input  logic [sfs_pkg::CFG_W-1:0] cfg_data
);
    import sfs_pkg::*;

    logic [BRAKE_W-1:0] braking_scale_reg;
    logic [DZ_W-1:0]    deadzone_reg;
    logic [STEEP_W-1:0] steepness_reg;
    logic               f_valid, f_ready, b_valid, b_ready;
    work_t              f_word, b_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            braking_scale_reg <= BRAKE_W'(256);
            deadzone_reg      <= '0;
            steepness_reg     <= STEEP_W'(1678);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_BRAKING:   braking_scale_reg <= cfg_data[BRAKE_W-1:0];
                CFG_DEADZONE:  deadzone_reg      <= cfg_data[DZ_W-1:0];
                CFG_STEEPNESS: steepness_reg     <= cfg_data[STEEP_W-1:0];
                default:       ;
            endcase
        end
    end

    sfs_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .frame         (frame),
        .braking_scale (braking_scale_reg),
        .work_valid    (f_valid),
        .work_ready    (f_ready),
        .work          (f_word)
    );

    sfs_queue #(.DEPTH(QDEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_word   (f_word),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_word  (b_word)
    );

    sfs_back #(.PEAK_FORCE(PEAK_FORCE), .ATAN_STEPS(ATAN_STEPS)) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .work_valid        (b_valid),
        .work_ready        (b_ready),
        .work              (b_word),
        .deadzone_fraction (deadzone_reg),
        .steep_scale       (steepness_reg),
        .empty             (empty),
        .pop               (pop),
        .result            (result)
    );

endmodule

[hw/rtl/sfs_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfs_checker
// Port-level checks of the steering force shaper, bound to the top level.
// ----------------------------------------------------------------------------
module sfs_checker #(
    parameter int PEAK_FORCE = sfs_pkg::PEAK_FORCE_DEF
) (
    input logic             clk,
    input logic             rst_n,
    input logic             empty,
    input logic             pop,
    input sfs_pkg::result_t result
);
    import sfs_pkg::*;

    localparam logic signed [OUT_N_W-1:0] PK = OUT_N_W'(PEAK_FORCE);

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result pending during reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("stalled result changed");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.force_newtons <= PK && result.force_newtons >= -PK))
        else $error("force beyond peak");

    a_sign: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((result.force_newtons == '0) == (result.force_fraction == '0)
                    && result.force_newtons[OUT_N_W-1]
                       == result.force_fraction[OUT_F_W-1]))
        else $error("fraction disagrees with force");

endmodule

bind steering_force_shaper_core sfs_checker #(.PEAK_FORCE(PEAK_FORCE)) u_sfs_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
